// ----- rtl/core/prs_pkg.sv -----
// shared types and constants for the prime range sum and minimum block
// used by prime_range_sum_and_min_core
package prs_pkg;

   localparam int INPUT_BITS    = 14;
   localparam int SUM_BITS      = 24;
   localparam int SMALLEST_BITS = 14;

   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_CHECK,
      ST_MOD,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/prs_prime_ram.sv -----
// synchronous memory holding the small primes used as trial divisors
// one write port, one read port with registered read data; no dependencies
module prs_prime_ram #(
   parameter int ADDR_BITS = 7,
   parameter int DATA_BITS = 7
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/prs_mod_unit.sv -----
// bit-serial restoring remainder unit, one dividend bit per cycle
// computes dividend mod divisor; no dependencies
module prs_mod_unit #(
   parameter int VALUE_BITS = 14,
   parameter int DIV_BITS   = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]   divisor,
   output logic                  done,
   output logic [DIV_BITS-1:0]   remainder
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] shreg_ff, shreg_in;
   logic [DIV_BITS-1:0]   div_ff, div_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS:0]     trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shreg_ff[VALUE_BITS-1]};
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shreg_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shreg_in = shreg_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_BITS'(trial - {1'b0, div_ff});
         end else begin
            rem_in = DIV_BITS'(trial);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/prime_range_sum_and_min_core.sv -----
// top level of the prime range sum and minimum block
// depends on prs_pkg, prs_prime_ram and prs_mod_unit
//
// usage: drive req_range_low / req_range_high and raise start; the item is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the result is out. the result appears for exactly one cycle with
// rsp_valid high: rsp_none_found, rsp_prime_sum (saturating at 24 bits) and
// rsp_smallest_prime. the receiver cannot stall; it must take the result then.
// after reset the block builds a table of all primes below 2**HB in its
// divisor memory (HB = ceil(VALUE_BITS/2)), testing each candidate against the
// primes already stored; busy is high for that whole build, and the table
// survives between items.
// per item: each number n of the range passes the candidate and next states,
// with a check state between them when n >= 2, and for every stored prime p
// with p*p <= n tried before a verdict, a pass through the serial remainder
// unit, which sets the rate. an empty range (low above high) goes straight to
// the result strobe and answers in the cycle right after it is taken.
module prime_range_sum_and_min_core #(
   parameter int VALUE_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [prs_pkg::INPUT_BITS-1:0]        req_range_low,
   input  logic [prs_pkg::INPUT_BITS-1:0]        req_range_high,
   output logic                                  rsp_valid,
   output logic                                  rsp_none_found,
   output logic [prs_pkg::SUM_BITS-1:0]          rsp_prime_sum,
   output logic [prs_pkg::SMALLEST_BITS-1:0]     rsp_smallest_prime
);

   import prs_pkg::*;

   localparam int HB = (VALUE_BITS + 1) / 2;
   localparam int SW = ((VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS) + 1;

   state_type             state_ff, state_in;
   logic                  build_ff, build_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [VALUE_BITS-1:0] hi_ff, hi_in;
   logic [HB-1:0]         idx_ff, idx_in;
   logic [HB-1:0]         count_ff, count_in;
   logic                  prime_ff, prime_in;
   logic                  found_ff, found_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [VALUE_BITS-1:0] least_ff, least_in;

   logic [VALUE_BITS-1:0] req_lo;
   logic [VALUE_BITS-1:0] req_hi;
   logic [VALUE_BITS-1:0] build_last;
   logic [HB-1:0]         div_data;
   logic [2*HB-1:0]       div_square;
   logic                  div_over;
   logic                  table_end;
   logic                  mod_start;
   logic                  mod_done;
   logic [HB-1:0]         mod_rem;
   logic                  wr_en;
   logic [SW-1:0]         sum_wide;

   assign req_lo     = VALUE_BITS'(req_range_low);
   assign req_hi     = VALUE_BITS'(req_range_high);
   assign build_last = VALUE_BITS'({HB{1'b1}});
   assign div_square = div_data * div_data;
   assign div_over   = div_square > (2*HB)'(cand_ff);
   assign table_end  = idx_ff == count_ff;
   assign sum_wide   = SW'(sum_ff) + SW'(cand_ff);

   prs_prime_ram #(
      .ADDR_BITS (HB),
      .DATA_BITS (HB)
   ) u_prime_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff),
      .wr_data (HB'(cand_ff)),
      .rd_addr (idx_in),
      .rd_data (div_data)
   );

   prs_mod_unit #(
      .VALUE_BITS (VALUE_BITS),
      .DIV_BITS   (HB)
   ) u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (cand_ff),
      .divisor   (div_data),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_lo > req_hi) ? ST_DONE : ST_CAND;
            end
         end
         ST_CAND: begin
            state_in = (cand_ff < VALUE_BITS'(2)) ? ST_NEXT : ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (table_end || div_over) ? ST_NEXT : ST_MOD;
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = (mod_rem == '0) ? ST_NEXT : ST_CHECK;
            end
         end
         ST_NEXT: begin
            if (build_ff) begin
               state_in = (cand_ff == build_last) ? ST_IDLE : ST_CAND;
            end else begin
               state_in = (cand_ff == hi_ff) ? ST_DONE : ST_CAND;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and control outputs
   always_comb begin
      build_in  = build_ff;
      cand_in   = cand_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      prime_in  = prime_ff;
      found_in  = found_ff;
      sum_in    = sum_ff;
      least_in  = least_ff;
      mod_start = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cand_in  = req_lo;
               hi_in    = req_hi;
               found_in = 1'b0;
               sum_in   = '0;
               least_in = '0;
            end
         end
         ST_CAND: begin
            idx_in   = '0;
            prime_in = 1'b0;
         end
         ST_CHECK: begin
            if (table_end || div_over) begin
               prime_in = 1'b1;
            end else begin
               mod_start = 1'b1;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               if (mod_rem == '0) begin
                  prime_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_NEXT: begin
            if (build_ff) begin
               if (prime_ff) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (cand_ff == build_last) begin
                  build_in = 1'b0;
               end else begin
                  cand_in = cand_ff + 1'b1;
               end
            end else begin
               if (prime_ff) begin
                  if (!found_ff) begin
                     found_in = 1'b1;
                     least_in = cand_ff;
                  end
                  if (sum_wide > SW'(SUM_MAX)) begin
                     sum_in = SUM_MAX;
                  end else begin
                     sum_in = SUM_BITS'(sum_wide);
                  end
               end
               if (cand_ff != hi_ff) begin
                  cand_in = cand_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CAND;
         build_ff <= 1'b1;
         cand_ff  <= VALUE_BITS'(2);
         idx_ff   <= '0;
         count_ff <= '0;
         prime_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         build_ff <= build_in;
         cand_ff  <= cand_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         prime_ff <= prime_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      sum_ff   <= sum_in;
      least_ff <= least_in;
   end

   assign busy               = state_ff != ST_IDLE;
   assign rsp_valid          = state_ff == ST_DONE;
   assign rsp_none_found     = !found_ff;
   assign rsp_prime_sum      = found_ff ? sum_ff : '0;
   assign rsp_smallest_prime = found_ff ? SMALLEST_BITS'(least_ff) : '0;

endmodule
